// ===== src/cfrf_pkg.sv =====
`timescale 1ns / 1ps

package cfrf_pkg;

  localparam int unsigned MaxNameDef = 40;
  localparam int unsigned HdrBytes   = 8;   // header, command, stick, time, date
  localparam int unsigned LenOffset  = 10;  // fixed bytes counted in the length field
  localparam int unsigned YearOffset = 20;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Control from the sequencer to the checksum adder
  typedef struct packed {
    logic       clear;
    logic       add;
    logic [7:0] data;
  } csum_ctrl_t;

endpackage

// ===== src/create_file_request_framer.sv =====
`timescale 1ns / 1ps

// Create-file request framer. Name words (kind 0) are taken one per cycle
// while no frame is sent and stored until a zero byte or MAX_NAME bytes. A
// request word (kind 1) starts a frame of name length + 10 bytes, sent one
// byte per cycle through the output register when it is not stalled; the
// input is not ready until the last byte is loaded, as the frame is walked by
// one step counter that feeds a single 16-bit checksum adder and reads the
// name memory one entry per unstalled cycle. command_code may be written at
// any time the block is idle; cfg_ready_o is always high.
module create_file_request_framer import cfrf_pkg::*; #(
  parameter int unsigned MAX_NAME = MaxNameDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] name_byte_i,
  input  logic [7:0] stick_number_i,
  input  logic [4:0] hour_i,
  input  logic [5:0] minute_i,
  input  logic [5:0] second_i,
  input  logic [6:0] year_i,
  input  logic [3:0] month_i,
  input  logic [4:0] day_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);

  localparam int unsigned LW = $clog2(MAX_NAME + 1);
  localparam int unsigned AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam int unsigned SW = $clog2(MAX_NAME + LenOffset);

  logic [7:0]      cmd_q;
  logic [LW-1:0]   len_q, len_d;
  logic            ended_q, ended_d;
  logic            busy_q, busy_d;
  logic [SW-1:0]   step_q, step_d;
  logic [LW-1:0]   ptr_q, ptr_d;
  logic [63:0]     fix_q, fix_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;

  logic            in_acc, req_acc, name_acc, mem_we, load;
  logic [SW-1:0]   name_end;
  logic            in_fixed, in_name, at_sum_hi, is_last;
  logic [7:0]      sel_byte, rd_data;
  logic [11:0]     len12;
  logic [3:0]      chk;
  logic [15:0]     tim, dat, sum;
  csum_ctrl_t      csum_ctrl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign req_acc     = in_acc && (kind_i == KIND_REQUEST);
  assign name_acc    = in_acc && (kind_i == KIND_NAME);
  assign mem_we      = name_acc && !ended_q && (name_byte_i != 8'd0)
                       && (len_q < LW'(MAX_NAME));

  // Fixed part of the frame, built when the request is taken
  assign len12 = 12'(len_q) + 12'(LenOffset);
  assign chk   = ~(len12[3:0] ^ len12[7:4] ^ len12[11:8]);
  assign tim   = {hour_i, minute_i, second_i[5:1]};
  assign dat   = {7'(year_i + 7'(YearOffset)), month_i, day_i};

  assign load      = busy_q && (!out_valid_q || out_ready_i);
  assign name_end  = SW'(HdrBytes) + SW'(len_q);
  assign in_fixed  = step_q < SW'(HdrBytes);
  assign in_name   = !in_fixed && (step_q < name_end);
  assign at_sum_hi = step_q == name_end;
  assign is_last   = !in_fixed && !in_name && !at_sum_hi;

  always_comb begin
    priority if (in_fixed) begin
      sel_byte = fix_q[63:56];
    end else if (in_name) begin
      sel_byte = rd_data;
    end else if (at_sum_hi) begin
      sel_byte = sum[15:8];
    end else begin
      sel_byte = sum[7:0];
    end
  end

  assign csum_ctrl.clear = req_acc;
  assign csum_ctrl.add   = load && (in_fixed || in_name);
  assign csum_ctrl.data  = sel_byte;

  always_comb begin
    len_d       = len_q;
    ended_d     = ended_q;
    busy_d      = busy_q;
    step_d      = step_q;
    ptr_d       = ptr_q;
    fix_d       = fix_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (name_acc && !ended_q) begin
      if (name_byte_i == 8'd0) begin
        ended_d = 1'b1;
      end else if (mem_we) begin
        len_d = len_q + LW'(1);
      end
    end

    if (req_acc) begin
      busy_d = 1'b1;
      step_d = '0;
      ptr_d  = '0;
      fix_d  = {chk, len12, cmd_q, stick_number_i, tim, dat};
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      out_last_d  = is_last;
      step_d      = step_q + SW'(1);
      fix_d       = {fix_q[55:0], 8'd0};
      if (in_name) begin
        ptr_d = ptr_q + LW'(1);
      end
      if (is_last) begin
        // frame done: drop the name
        busy_d  = 1'b0;
        len_d   = '0;
        ended_d = 1'b0;
        ptr_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      len_q       <= '0;
      ended_q     <= 1'b0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cmd_q <= cfg_data_i;
      end
      len_q       <= len_d;
      ended_q     <= ended_d;
      busy_q      <= busy_d;
      step_q      <= step_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fix_q      <= fix_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  // Read address runs one ahead so the registered data matches ptr_q
  cfrf_name_mem #(
    .MAX_NAME (MAX_NAME),
    .AW       (AW)
  ) u_name_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (len_q[AW-1:0]),
    .wr_data_i (name_byte_i),
    .rd_addr_i (ptr_d[AW-1:0]),
    .rd_data_o (rd_data)
  );

  cfrf_csum u_csum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (csum_ctrl),
    .sum_o  (sum)
  );

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

endmodule

// ===== src/cfrf_name_mem.sv =====
`timescale 1ns / 1ps

module cfrf_name_mem import cfrf_pkg::*; #(
  parameter int unsigned MAX_NAME = MaxNameDef,
  parameter int unsigned AW       = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [MAX_NAME];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/cfrf_csum.sv =====
`timescale 1ns / 1ps

module cfrf_csum import cfrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  csum_ctrl_t ctrl_i,
  output logic [15:0] sum_o
);

  logic [15:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.add) begin
      sum_d = sum_q + {8'd0, ctrl_i.data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== src/cfrf_checker.sv =====
`timescale 1ns / 1ps

module cfrf_checker import cfrf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       kind_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_o,
  input logic       last_byte_o
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o))
    else $error("output word changed while stalled");

  // a taken request closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_REQUEST) |=> !in_ready_o)
    else $error("input ready during frame");

  // a frame streams without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_valid_o && out_ready_i |=> out_valid_o)
    else $error("gap inside frame");

  // input reopens only once the last word is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && last_byte_o)
    else $error("input reopened before end of frame");

endmodule

bind create_file_request_framer cfrf_checker u_cfrf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .kind_i       (kind_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);

// ===== tb/frame_tracker_pkg.sv =====
`timescale 1ns / 1ps

package frame_tracker_pkg;
  import cfrf_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
    logic [7:0] stick;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } req_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  class frame_tracker;
    frame_out_t  due_bytes[$];
    logic [7:0]  command_code;
    logic [7:0]  name_buf[MaxNameDef];
    int unsigned name_len;
    bit          name_done;
    logic [15:0] run_sum;
    int unsigned mismatches;
    int unsigned used_words;
    int unsigned frames;
    int unsigned bytes_seen;

    function new();
      command_code = '0;
      name_len     = 0;
      name_done    = 1'b0;
      run_sum      = '0;
      mismatches   = 0;
      used_words   = 0;
      frames       = 0;
      bytes_seen   = 0;
    endfunction

    function void set_command(logic [7:0] code);
      command_code = code;
    endfunction

    function void queue_byte(logic [7:0] data, logic last);
      due_bytes.push_back({data, last});
      run_sum += 16'(data);
    endfunction

    // Note one accepted input word; a request queues its whole frame.
    function void take_word(req_word_t w);
      logic [11:0] flen;
      logic [15:0] hdr;
      logic [15:0] clock_field;
      logic [15:0] date_field;
      logic [15:0] csum;
      logic [6:0]  year_field;
      int unsigned i;
      if (w.kind == KIND_NAME) begin
        // drop bytes past the terminator or beyond a full store
        if (name_done || (w.name_byte != 8'h00 && name_len >= MaxNameDef)) return;
        if (w.name_byte == 8'h00) begin
          name_done = 1'b1;
        end else begin
          name_buf[name_len] = w.name_byte;
          name_len++;
        end
        used_words++;
        return;
      end
      flen        = 12'(name_len + LenOffset);
      hdr         = {~(flen[3:0] ^ flen[7:4] ^ flen[11:8]), flen};
      clock_field = {w.hour, w.minute, w.second[5:1]};
      year_field  = 7'(w.year + YearOffset);
      date_field  = {year_field, w.month, w.day};
      run_sum     = '0;
      queue_byte(hdr[15:8], 1'b0);
      queue_byte(hdr[7:0], 1'b0);
      queue_byte(command_code, 1'b0);
      queue_byte(w.stick, 1'b0);
      queue_byte(clock_field[15:8], 1'b0);
      queue_byte(clock_field[7:0], 1'b0);
      queue_byte(date_field[15:8], 1'b0);
      queue_byte(date_field[7:0], 1'b0);
      for (i = 0; i < name_len; i++) queue_byte(name_buf[i], 1'b0);
      csum = run_sum;
      queue_byte(csum[15:8], 1'b0);
      queue_byte(csum[7:0], 1'b1);
      name_len  = 0;
      name_done = 1'b0;
      used_words++;
      frames++;
    endfunction

    task report(string msg);
      mismatches++;
      // hold the log to a readable length
      if (mismatches <= 100) $display("mismatch: %s", msg);
    endtask

    task check_byte(logic [7:0] data, logic last);
      frame_out_t want;
      if (due_bytes.size() == 0) begin
        report($sformatf("frame byte %02h with no frame pending", data));
        return;
      end
      want = due_bytes.pop_front();
      if (data !== want.data)
        report($sformatf("frame byte %0d: got %02h, want %02h", bytes_seen, data, want.data));
      if (last !== want.last)
        report($sformatf("frame byte %0d: last flag %b, want %b", bytes_seen, last, want.last));
      bytes_seen++;
    endtask

    task finish_check();
      if (due_bytes.size() != 0)
        report($sformatf("%0d frame bytes still due at end of run", due_bytes.size()));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cfrf_pkg::*;
  import frame_tracker_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned SettleTicks = 8;
  localparam int unsigned PhaseWords  = 95;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  req_word_t  in_word     = '0;
  logic       kind_i;
  logic [7:0] name_byte_i;
  logic [7:0] stick_number_i;
  logic [4:0] hour_i;
  logic [5:0] minute_i;
  logic [5:0] second_i;
  logic [6:0] year_i;
  logic [3:0] month_i;
  logic [4:0] day_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] frame_byte_o;
  logic       last_byte_o;

  frame_tracker tracker;
  int unsigned  idle_cycles = 0;
  int unsigned  cfg_writes  = 0;
  bit           no_gaps     = 1'b0;

  assign kind_i         = in_word.kind;
  assign name_byte_i    = in_word.name_byte;
  assign stick_number_i = in_word.stick;
  assign hour_i         = in_word.hour;
  assign minute_i       = in_word.minute;
  assign second_i       = in_word.second;
  assign year_i         = in_word.year;
  assign month_i        = in_word.month;
  assign day_i          = in_word.day;

  create_file_request_framer dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sample every handshake on the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.set_command(cfg_data_i);
        cfg_writes++;
      end
      if (in_valid_i && in_ready_o) tracker.take_word(in_word);
      if (out_valid_o && out_ready_i) tracker.check_byte(frame_byte_o, last_byte_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("no word moved for %0d cycles", IdleLimit);
    $display("FAIL create_file_request_framer");
    $finish;
  end

  // Receiver: short stalls mostly, a few long ones, and long ready stretches.
  initial begin
    int unsigned run, stall, r;
    wait (rst_ni == 1'b1);
    @(posedge clk_i);
    forever begin
      r     = $urandom_range(99);
      run   = (r < 15) ? $urandom_range(150, 30) : $urandom_range(8, 1);
      r     = $urandom_range(99);
      stall = (r < 70) ? $urandom_range(3, 1) :
              (r < 92) ? $urandom_range(10, 4) : $urandom_range(40, 15);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      out_ready_i <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic req_word_t name_word(logic [7:0] b);
    req_word_t w;
    w.kind      = KIND_NAME;
    w.name_byte = b;
    w.stick     = 8'($urandom);
    w.hour      = 5'($urandom);
    w.minute    = 6'($urandom);
    w.second    = 6'($urandom);
    w.year      = 7'($urandom);
    w.month     = 4'($urandom);
    w.day       = 5'($urandom);
    return w;
  endfunction

  function automatic req_word_t request_word(logic [7:0] stick, logic [4:0] hr,
                                             logic [5:0] mi, logic [5:0] se,
                                             logic [6:0] yr, logic [3:0] mo,
                                             logic [4:0] dy);
    req_word_t w;
    w.kind      = KIND_REQUEST;
    w.name_byte = 8'($urandom);
    w.stick     = stick;
    w.hour      = hr;
    w.minute    = mi;
    w.second    = se;
    w.year      = yr;
    w.month     = mo;
    w.day       = dy;
    return w;
  endfunction

  function automatic req_word_t random_request(bit full_width);
    if (full_width)
      return request_word(8'($urandom), 5'($urandom), 6'($urandom), 6'($urandom),
                          7'($urandom), 4'($urandom), 5'($urandom));
    return request_word(8'($urandom), 5'($urandom_range(23)), 6'($urandom_range(59)),
                        6'($urandom_range(59)), 7'($urandom_range(99)),
                        4'($urandom_range(12, 1)), 5'($urandom_range(31, 1)));
  endfunction

  task automatic send_word(req_word_t w);
    int unsigned gap;
    gap = pick_gap();
    in_valid_i <= 1'b1;
    in_word    <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_command(logic [7:0] code);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the sender until every queued frame byte has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.due_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic send_random_request(bit long_name);
    int unsigned nlen, cut, tail, r, i;
    r = $urandom_range(99);
    if (long_name || r < 12) nlen = $urandom_range(50, 41);
    else if (r < 22) nlen = 0;
    else if (r < 30) nlen = $urandom_range(40, 13);
    else nlen = $urandom_range(12, 1);
    no_gaps = ($urandom_range(3) == 0);
    // break about one name in ten with an early zero
    cut = ($urandom_range(9) == 0) ? $urandom_range(nlen) : nlen + 1;
    for (i = 0; i < nlen; i++)
      send_word(name_word((i == cut) ? 8'h00 : 8'($urandom_range(255, 1))));
    if ($urandom_range(9) < 6) begin
      send_word(name_word(8'h00));
      tail = ($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0;
      for (i = 0; i < tail; i++) send_word(name_word(8'($urandom)));
    end
    send_word(random_request($urandom_range(3) == 0));
    no_gaps = 1'b0;
    if ($urandom_range(11) == 0) settle();
  endtask

  initial begin
    int unsigned ph, goal;
    logic [7:0]  code;
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_command(8'hFF);
    // empty name, every clock field at zero
    send_word(request_word(8'h00, 5'd0, 6'd0, 6'd0, 7'd0, 4'd0, 5'd0));
    // bytes after the terminator are dropped; clock fields at full width
    send_word(name_word(8'hFF));
    send_word(name_word(8'h01));
    send_word(name_word(8'h80));
    send_word(name_word(8'h7F));
    send_word(name_word(8'h00));
    send_word(name_word(8'h41));
    send_word(name_word(8'h00));
    send_word(request_word(8'hFF, 5'h1F, 6'h3F, 6'h3F, 7'h7F, 4'hF, 5'h1F));
    // top of the year slot, then just past it so the year wraps
    send_word(name_word(8'h61));
    send_word(request_word(8'h5A, 5'd23, 6'd59, 6'd59, 7'd107, 4'd12, 5'd31));
    send_word(name_word(8'h62));
    send_word(name_word(8'h63));
    send_word(request_word(8'hA5, 5'd0, 6'd1, 6'd1, 7'd108, 4'd1, 5'd1));
    // a leading zero leaves the name empty
    send_word(name_word(8'h00));
    send_word(name_word(8'h78));
    send_word(request_word(8'h01, 5'd12, 6'd30, 6'd2, 7'd99, 4'd6, 5'd15));
    settle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: code = 8'h00;
        2: code = 8'h80;
        default: code = 8'($urandom);
      endcase
      write_command(code);
      goal = tracker.used_words + PhaseWords;
      send_random_request(1'b1);
      while (tracker.used_words < goal) send_random_request(1'b0);
      settle();
    end

    tracker.finish_check();
    $display("covered %0d effective input words in %0d frames, %0d frame bytes compared",
             tracker.used_words, tracker.frames, tracker.bytes_seen);
    $display("command byte written %0d times incl. 0x00 and 0xFF; names empty, cut and overlong",
             cfg_writes);
    if (tracker.mismatches == 0) begin
      $display("PASS create_file_request_framer");
    end else begin
      $display("FAIL create_file_request_framer");
    end
    $finish;
  end

endmodule
